// ----- rtl/core/wprl_pkg.sv -----
// Shared types and constants for the windowed pulse rate limiter.
// Used by windowed_pulse_rate_limiter_top; depends on nothing else.
`default_nettype none

package wprl_pkg;

   // field widths
   localparam int unsigned STAMP_BITS   = 48;
   localparam int unsigned PAYLOAD_BITS = 32;
   localparam int unsigned DATA_BITS    = STAMP_BITS + PAYLOAD_BITS;
   localparam int unsigned CFG_BITS     = 32;
   localparam int unsigned HI_BITS      = STAMP_BITS - 32;
   localparam int unsigned PROD_BITS    = STAMP_BITS + CFG_BITS;
   localparam int unsigned LHS_BITS     = 64;

   // default storage depth
   localparam int unsigned DEF_FIFO_DEPTH = 32;

   // one pulse per second in Q16.16 times microseconds per second
   localparam logic [LHS_BITS-1:0] RATE_SCALE = 64'd65536000000;

   // register map
   localparam int unsigned CSR_ADDR_BITS = 4;
   localparam logic [1:0]  CSR_WINDOW    = 2'd0;
   localparam logic [1:0]  CSR_MAX_RATE  = 2'd1;
   localparam logic [1:0]  CSR_SPACING   = 2'd2;

   localparam logic [CFG_BITS-1:0] WINDOW_RST   = 32'd1000000;
   localparam logic [CFG_BITS-1:0] MAX_RATE_RST = 32'd1310720;
   localparam logic [CFG_BITS-1:0] SPACING_RST  = 32'd1000000;

   // result kinds
   typedef enum logic [1:0] {
      KIND_FWD  = 2'd0,
      KIND_MARK = 2'd1,
      KIND_NONE = 2'd2
   } kind_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOP,
      ST_FETCH,
      ST_JUDGE,
      ST_DONE
   } state_type;

   typedef struct packed {
      kind_type                  kind;
      logic [PAYLOAD_BITS-1:0]   payload;
      logic [STAMP_BITS-1:0]     stamp;
   } result_type;

endpackage

`default_nettype wire

// ----- rtl/core/windowed_pulse_rate_limiter_top.sv -----
// Windowed pulse rate limiter: pulse FIFO in one synchronous memory, rate judge
// and bogus-burst marker logic. Depends on wprl_pkg.
//
//   channel | dir | handshake              | contents
//   --------+-----+------------------------+--------------------------------------
//   req     | in  | req_tvalid/req_tready  | tdata: stamp_us, payload; tuser: command
//   rsp     | out | rsp_tvalid/rsp_tready  | tdata: out_stamp_us, out_payload;
//           |     |                        | tuser: kind; tlast: last
//   csr     | in  | APB, pready tied high  | window_us, max_rate_q16, bogus_spacing_us
//
// An item passes through accept, occupancy check and finish steps with at most one
// pulse buffered, and through a span check too when that check ends without a decision;
// each judged pulse adds a memory read of the head entry, a split multiply, and a
// decide and pop step. The single read port of the pulse memory serializes them.
// Reset is synchronous; the memory is never cleared, only occupied entries feed the judge.
// A full result register holds the sequencer only when a further result must
// leave; the next item is accepted while the final result still waits.
`default_nettype none

module windowed_pulse_rate_limiter_top #(
   parameter int unsigned FIFO_DEPTH = wprl_pkg::DEF_FIFO_DEPTH
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // pulse input
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [wprl_pkg::DATA_BITS-1:0]        req_tdata,   // [47:0] stamp_us, [79:48] payload
   input  logic                                  req_tuser,   // [0] command
   // results
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [wprl_pkg::DATA_BITS-1:0]        rsp_tdata,   // [47:0] out_stamp_us, [79:48] out_payload
   output logic [1:0]                            rsp_tuser,   // [1:0] kind
   output logic                                  rsp_tlast,
   // configuration
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [wprl_pkg::CSR_ADDR_BITS-1:0]    csr_paddr,
   input  logic [wprl_pkg::CFG_BITS-1:0]         csr_pwdata,
   output logic [wprl_pkg::CFG_BITS-1:0]         csr_prdata,
   output logic                                  csr_pready
);

   import wprl_pkg::*;

   localparam int unsigned IDX_W = $clog2(FIFO_DEPTH);
   localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FIFO_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(FIFO_DEPTH);
   localparam logic [IDX_W:0]   DEPTH_X  = (IDX_W + 1)'(FIFO_DEPTH);

   // pulse storage: {payload, stamp}
   logic [DATA_BITS-1:0] fifo_mem [FIFO_DEPTH];
   logic [DATA_BITS-1:0] rd_q_ff;

   // state and registers
   state_type state_ff, state_in;
   logic [IDX_W-1:0]        head_ff, head_in;
   logic [CNT_W-1:0]        fill_ff, fill_in;
   logic [STAMP_BITS-1:0]   tail_ff, tail_in;
   logic [STAMP_BITS-1:0]   last_mark_ff, last_mark_in;
   logic                    mark_seen_ff, mark_seen_in;
   logic                    flush_ff, flush_in;
   logic [CFG_BITS-1:0]     window_ff, window_in;
   logic [CFG_BITS-1:0]     max_rate_ff, max_rate_in;
   logic [CFG_BITS-1:0]     spacing_ff, spacing_in;
   logic [63:0]             lo_prod_ff, lo_prod_in;
   logic [HI_BITS+31:0]     hi_prod_ff, hi_prod_in;
   logic [LHS_BITS-1:0]     lhs_ff, lhs_in;
   logic                    mark_ok_ff, mark_ok_in;
   result_type              pend_ff, pend_in;
   logic                    pend_vld_ff, pend_vld_in;
   result_type              out_ff, out_in;
   logic                    out_vld_ff, out_vld_in;
   logic                    out_last_ff, out_last_in;

   // control
   logic                    accept;
   logic                    push_en;
   logic                    out_free;
   logic                    judge_go;
   logic                    rate_ok;
   logic                    fwd;
   logic                    mark;
   logic                    emit;
   logic                    pop;
   logic                    cfg_wr;
   logic [1:0]              cfg_idx;
   logic [IDX_W:0]          slot_sum;
   logic [IDX_W-1:0]        slot;
   logic [STAMP_BITS-1:0]   front;
   logic [STAMP_BITS-1:0]   span;
   logic [PROD_BITS-1:0]    prod;
   result_type              res_new;
   result_type              res_none;

   // memory: one write at push, head read every cycle
   always_ff @(posedge clock) begin
      if (push_en) begin
         fifo_mem[slot] <= req_tdata;
      end
      rd_q_ff <= fifo_mem[head_ff];
   end

   // datapath decode
   assign front    = rd_q_ff[STAMP_BITS-1:0];
   assign span     = tail_ff - front;
   assign slot_sum = (IDX_W + 1)'(head_ff) + (IDX_W + 1)'(fill_ff);
   assign slot     = (slot_sum >= DEPTH_X) ? IDX_W'(slot_sum - DEPTH_X) : IDX_W'(slot_sum);
   assign prod     = {hi_prod_ff, 32'd0} + PROD_BITS'(lo_prod_ff);
   assign rate_ok  = PROD_BITS'(lhs_ff) <= prod;
   assign out_free = !out_vld_ff || rsp_tready;
   assign judge_go = flush_ff || (span >= STAMP_BITS'(window_ff)) || (fill_ff == FULL_CNT);

   // control outputs of the sequencer
   always_comb begin
      req_tready = 1'b0;
      fwd        = 1'b0;
      mark       = 1'b0;
      pop        = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
         end
         ST_JUDGE: begin
            fwd  = rate_ok;
            mark = !rate_ok && !flush_ff && mark_ok_ff;
            pop  = !((fwd || mark) && pend_vld_ff && !out_free);
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   assign emit    = fwd || mark;
   assign accept  = req_tvalid && req_tready;
   assign push_en = accept && !req_tuser && (fill_ff < FULL_CNT);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (accept) state_in = ST_LOOP;
         ST_LOOP:  state_in = (fill_ff > CNT_W'(1)) ? ST_FETCH : ST_DONE;
         ST_FETCH: state_in = judge_go ? ST_JUDGE : ST_DONE;
         ST_JUDGE: if (pop) state_in = ST_LOOP;
         ST_DONE:  if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // result records
   always_comb begin
      res_new.kind    = fwd ? KIND_FWD : KIND_MARK;
      res_new.payload = rd_q_ff[DATA_BITS-1:STAMP_BITS];
      res_new.stamp   = front;
      res_none.kind    = KIND_NONE;
      res_none.payload = '0;
      res_none.stamp   = '0;
   end

   // fifo pointers, judge pipeline and result registers
   always_comb begin
      head_in      = head_ff;
      fill_in      = fill_ff;
      tail_in      = tail_ff;
      last_mark_in = last_mark_ff;
      mark_seen_in = mark_seen_ff;
      flush_in     = flush_ff;
      lo_prod_in   = lo_prod_ff;
      hi_prod_in   = hi_prod_ff;
      lhs_in       = lhs_ff;
      mark_ok_in   = mark_ok_ff;
      pend_in      = pend_ff;
      pend_vld_in  = pend_vld_ff;
      out_in       = out_ff;
      out_last_in  = out_last_ff;
      out_vld_in   = out_vld_ff && !rsp_tready;

      if (accept) begin
         flush_in = req_tuser;
      end
      if (push_en) begin
         tail_in = req_tdata[STAMP_BITS-1:0];
         fill_in = fill_ff + CNT_W'(1);
      end

      // split multiply, count term and marker spacing test
      if (state_ff == ST_FETCH) begin
         lo_prod_in = 64'(span[31:0]) * 64'(max_rate_ff);
         hi_prod_in = (HI_BITS + 32)'(span[STAMP_BITS-1:32]) * (HI_BITS + 32)'(max_rate_ff);
         lhs_in     = LHS_BITS'(fill_ff - CNT_W'(1)) * RATE_SCALE;
         mark_ok_in = !mark_seen_ff ||
                      ((front - last_mark_ff) >= STAMP_BITS'(spacing_ff));
      end

      // decide, pop, and hold the newest result until its last flag is known
      if (pop) begin
         head_in = (head_ff == LAST_IDX) ? '0 : head_ff + IDX_W'(1);
         fill_in = fill_ff - CNT_W'(1);
         if (mark) begin
            last_mark_in = front;
            mark_seen_in = 1'b1;
         end
         if (emit) begin
            pend_in     = res_new;
            pend_vld_in = 1'b1;
            if (pend_vld_ff) begin
               out_in      = pend_ff;
               out_last_in = 1'b0;
               out_vld_in  = 1'b1;
            end
         end
      end

      // final beat of the item
      if (state_ff == ST_DONE && out_free) begin
         out_in      = pend_vld_ff ? pend_ff : res_none;
         out_last_in = 1'b1;
         out_vld_in  = 1'b1;
         pend_vld_in = 1'b0;
      end
   end

   // configuration writes and reads
   assign cfg_idx    = csr_paddr[CSR_ADDR_BITS-1:2];
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_comb begin
      window_in   = window_ff;
      max_rate_in = max_rate_ff;
      spacing_in  = spacing_ff;
      if (cfg_wr) begin
         case (cfg_idx)
            CSR_WINDOW:   window_in   = csr_pwdata;
            CSR_MAX_RATE: max_rate_in = csr_pwdata;
            CSR_SPACING:  spacing_in  = csr_pwdata;
            default:      window_in   = window_ff;
         endcase
      end
   end

   always_comb begin
      case (cfg_idx)
         CSR_WINDOW:   csr_prdata = window_ff;
         CSR_MAX_RATE: csr_prdata = max_rate_ff;
         CSR_SPACING:  csr_prdata = spacing_ff;
         default:      csr_prdata = '0;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         fill_ff      <= '0;
         last_mark_ff <= '0;
         mark_seen_ff <= 1'b0;
         flush_ff     <= 1'b0;
         pend_vld_ff  <= 1'b0;
         out_vld_ff   <= 1'b0;
         window_ff    <= WINDOW_RST;
         max_rate_ff  <= MAX_RATE_RST;
         spacing_ff   <= SPACING_RST;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         last_mark_ff <= last_mark_in;
         mark_seen_ff <= mark_seen_in;
         flush_ff     <= flush_in;
         pend_vld_ff  <= pend_vld_in;
         out_vld_ff   <= out_vld_in;
         window_ff    <= window_in;
         max_rate_ff  <= max_rate_in;
         spacing_ff   <= spacing_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      tail_ff     <= tail_in;
      lo_prod_ff  <= lo_prod_in;
      hi_prod_ff  <= hi_prod_in;
      lhs_ff      <= lhs_in;
      mark_ok_ff  <= mark_ok_in;
      pend_ff     <= pend_in;
      out_ff      <= out_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {out_ff.payload, out_ff.stamp};
   assign rsp_tuser  = out_ff.kind;
   assign rsp_tlast  = out_last_ff;

`ifndef SYNTHESIS
   // occupancy never passes the depth
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FULL_CNT)
      else $error("fifo fill above depth");

   // a finished item always leaves room for the next push
   a_idle_room: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (fill_ff < FULL_CNT))
      else $error("fifo full while idle");

   // no held result survives the end of an item
   a_idle_no_pend: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !pend_vld_ff)
      else $error("held result left over at idle");

   // a pop always leaves at least one pulse buffered
   a_pop_keeps_one: assert property (@(posedge clock) disable iff (reset)
      pop |-> (fill_ff > CNT_W'(1)))
      else $error("pop with one or no pulse buffered");

   // head advances only through a pop
   a_head_move: assert property (@(posedge clock) disable iff (reset)
      !pop |=> $stable(head_ff))
      else $error("head moved without pop");
`endif

endmodule

`default_nettype wire

// ----- tb/windowed_pulse_rate_limiter_top_tb.sv -----
`timescale 1ns / 1ps
// Testbench for windowed_pulse_rate_limiter_top: directed and random pulse streams,
// checked beat by beat against a behavioral rate-limiter model kept in this file.
// Depends on wprl_pkg and the top-level RTL only.

module windowed_pulse_rate_limiter_top_tb;
   import wprl_pkg::*;

   localparam int unsigned DEPTH     = DEF_FIFO_DEPTH;
   localparam logic        CMD_PUSH  = 1'b0;
   localparam logic        CMD_FLUSH = 1'b1;

   typedef struct packed {
      logic                    flush;
      logic [STAMP_BITS-1:0]   stamp;
      logic [PAYLOAD_BITS-1:0] payload;
   } pulse_type;

   typedef struct packed {
      kind_type                kind;
      logic [STAMP_BITS-1:0]   stamp;
      logic [PAYLOAD_BITS-1:0] payload;
      logic                    last;
   } beat_type;

   // clock and DUT pins, the bench-driven ones known from time zero
   logic                      clock       = 1'b0;
   logic                      reset       = 1'b1;
   logic                      req_tvalid  = 1'b0;
   logic                      req_tready;
   logic [DATA_BITS-1:0]      req_tdata   = '0;    // [47:0] stamp_us, [79:48] payload
   logic                      req_tuser   = 1'b0;  // [0] command
   logic                      rsp_tvalid;
   logic                      rsp_tready  = 1'b0;
   logic [DATA_BITS-1:0]      rsp_tdata;           // [47:0] out_stamp_us, [79:48] out_payload
   logic [1:0]                rsp_tuser;           // [1:0] kind
   logic                      rsp_tlast;
   logic                      csr_psel    = 1'b0;
   logic                      csr_penable = 1'b0;
   logic                      csr_pwrite  = 1'b0;
   logic [CSR_ADDR_BITS-1:0]  csr_paddr   = '0;
   logic [CFG_BITS-1:0]       csr_pwdata  = '0;
   logic [CFG_BITS-1:0]       csr_prdata;
   logic                      csr_pready;

   // stimulus and scoreboard storage
   pulse_type pending_pulses[$];
   beat_type  expected_results[$];
   pulse_type next_pulse;
   beat_type  seen_beat;
   beat_type  want_beat;
   int        error_count = 0;
   int        beat_count  = 0;

   // model state and its copy of the registers
   logic [STAMP_BITS-1:0]   held_stamp   [DEPTH];
   logic [PAYLOAD_BITS-1:0] held_payload [DEPTH];
   int unsigned             head_slot    = 0;
   int unsigned             fill_level   = 0;
   logic [STAMP_BITS-1:0]   marker_stamp = '0;
   logic                    marker_sent  = 1'b0;
   logic [CFG_BITS-1:0]     cfg_window   = WINDOW_RST;
   logic [CFG_BITS-1:0]     cfg_rate     = MAX_RATE_RST;
   logic [CFG_BITS-1:0]     cfg_spacing  = SPACING_RST;

   // idling state of both sides
   int send_gap   = 0;
   int send_calm  = 0;
   int recv_wait  = 0;
   int recv_calm  = 0;
   int hold_left  = 0;
   logic hold_done = 1'b0;

   logic [STAMP_BITS-1:0] stamp_now;

   windowed_pulse_rate_limiter_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #10 clock = ~clock;

   // (count-1) * 1e6 * 65536 <= rate * span, done at full width
   function automatic logic within_rate(input int unsigned count,
                                        input logic [STAMP_BITS-1:0] span);
      logic [79:0] allowed;
      logic [79:0] needed;
      allowed = {32'd0, span} * {48'd0, cfg_rate};
      needed  = 80'(count - 1) * 80'd65536000000;
      return needed <= allowed;
   endfunction

   // append one predicted result beat, last flag cleared
   task automatic queue_expected(input kind_type kind, input logic [STAMP_BITS-1:0] stamp,
                                 input logic [PAYLOAD_BITS-1:0] payload);
      beat_type item;
      item = '{kind, stamp, payload, 1'b0};
      expected_results.insert(expected_results.size(), item);
   endtask

   // one accepted input beat: update the buffer and queue the results it causes
   task automatic rate_limit_step(input logic flush, input logic [STAMP_BITS-1:0] stamp,
                                  input logic [PAYLOAD_BITS-1:0] payload);
      int unsigned           tail;
      int unsigned           produced;
      logic                  judging;
      logic [STAMP_BITS-1:0] front;
      logic [STAMP_BITS-1:0] span;
      produced = 0;
      judging  = 1'b1;
      if (!flush && fill_level < DEPTH) begin
         held_stamp[(head_slot + fill_level) % DEPTH]   = stamp;
         held_payload[(head_slot + fill_level) % DEPTH] = payload;
         fill_level++;
      end
      while (judging && fill_level > 1) begin
         tail  = (head_slot + fill_level - 1) % DEPTH;
         front = held_stamp[head_slot];
         span  = held_stamp[tail] - front;
         if (!flush && span < cfg_window && fill_level < DEPTH) begin
            judging = 1'b0;
         end else begin
            if (within_rate(fill_level, span)) begin
               queue_expected(KIND_FWD, front, held_payload[head_slot]);
               produced++;
            end else if (!flush && (!marker_sent || front - marker_stamp >= cfg_spacing)) begin
               marker_stamp = front;
               marker_sent  = 1'b1;
               queue_expected(KIND_MARK, front, held_payload[head_slot]);
               produced++;
            end
            head_slot = (head_slot + 1) % DEPTH;
            fill_level--;
         end
      end
      if (produced == 0)
         queue_expected(KIND_NONE, '0, '0);
      expected_results[expected_results.size() - 1].last = 1'b1;
   endtask

   // gap lengths: mostly short, a few long, with quiet stretches of none
   function automatic int draw_gap(inout int calm_left);
      int roll;
      roll = $urandom_range(0, 99);
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if (roll < 4) begin
         calm_left = $urandom_range(20, 80);
         return 0;
      end
      if (roll < 45) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 96) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // sender: offers queued pulses, predicts on each accepted beat
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap   = 0;
      end else begin
         if (req_tvalid && req_tready)
            rate_limit_step(req_tuser, req_tdata[STAMP_BITS-1:0], req_tdata[DATA_BITS-1:STAMP_BITS]);
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_pulses.size() > 0) begin
               next_pulse = pending_pulses[0];
               pending_pulses.delete(0);
               req_tuser  <= next_pulse.flush;
               req_tdata  <= {next_pulse.payload, next_pulse.stamp};
               req_tvalid <= 1'b1;
               send_gap   = draw_gap(send_calm);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // receiver: checks each result beat, stalls at random, holds off once for a long time
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            beat_count++;
            seen_beat = '{kind_type'(rsp_tuser), rsp_tdata[STAMP_BITS-1:0],
                          rsp_tdata[DATA_BITS-1:STAMP_BITS], rsp_tlast};
            if (expected_results.size() == 0) begin
               error_count++;
               $display("%0t: unexpected result kind %0d stamp %h payload %h last %b",
                        $time, seen_beat.kind, seen_beat.stamp, seen_beat.payload,
                        seen_beat.last);
            end else begin
               want_beat = expected_results[0];
               expected_results.delete(0);
               if (seen_beat !== want_beat) begin
                  error_count++;
                  $display("%0t: expected kind %0d stamp %h payload %h last %b",
                           $time, want_beat.kind, want_beat.stamp, want_beat.payload,
                           want_beat.last);
                  $display("%0t:   actual kind %0d stamp %h payload %h last %b",
                           $time, seen_beat.kind, seen_beat.stamp, seen_beat.payload,
                           seen_beat.last);
               end
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (!hold_done && beat_count >= 150) begin
            // long back-pressure so the block fills and stalls its input
            hold_done = 1'b1;
            hold_left = 500;
            rsp_tready <= 1'b0;
         end else if (recv_wait > 0) begin
            recv_wait--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            recv_wait = draw_gap(recv_calm);
         end
      end
   end

   // one APB transfer, setup then access
   task automatic csr_access(input logic wr, input logic [1:0] idx,
                             input logic [CFG_BITS-1:0] wdata,
                             output logic [CFG_BITS-1:0] rdata);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic verify_register(input logic [1:0] idx, input logic [CFG_BITS-1:0] want);
      logic [CFG_BITS-1:0] got;
      csr_access(1'b0, idx, '0, got);
      if (got !== want) begin
         error_count++;
         $display("%0t: register %0d read expected %h actual %h", $time, idx, want, got);
      end
   endtask

   task automatic program_register(input logic [1:0] idx, input logic [CFG_BITS-1:0] value);
      logic [CFG_BITS-1:0] unused;
      csr_access(1'b1, idx, value, unused);
      case (idx)
         CSR_WINDOW:   cfg_window  = value;
         CSR_MAX_RATE: cfg_rate    = value;
         CSR_SPACING:  cfg_spacing = value;
         default: ;
      endcase
      verify_register(idx, value);
   endtask

   task automatic add_pulse(input logic flush, input logic [STAMP_BITS-1:0] stamp,
                            input logic [PAYLOAD_BITS-1:0] payload);
      pulse_type item;
      item = '{flush, stamp, payload};
      pending_pulses.insert(pending_pulses.size(), item);
   endtask

   // block is idle: all sent, all results back, plus a margin of idle clocks
   task automatic wait_drained();
      while (pending_pulses.size() != 0 || req_tvalid || expected_results.size() != 0)
         @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   // mostly nondecreasing stamps scaled to the window, some bursts, repeats,
   // backward steps and flushes
   task automatic run_phase(input logic [CFG_BITS-1:0] window, input logic [CFG_BITS-1:0] rate,
                            input logic [CFG_BITS-1:0] spacing, input int items);
      logic [31:0] base;
      logic [31:0] burst;
      int          roll;
      program_register(CSR_WINDOW, window);
      program_register(CSR_MAX_RATE, rate);
      program_register(CSR_SPACING, spacing);
      base      = (window / 8 < 16) ? 32'd16 : window / 8;
      burst     = base / 16 + 1;
      stamp_now = STAMP_BITS'({$urandom, $urandom});
      repeat (items) begin
         roll = $urandom_range(0, 99);
         if (roll < 5) begin
            add_pulse(CMD_FLUSH, STAMP_BITS'({$urandom, $urandom}), $urandom);
         end else begin
            if (roll >= 8 && roll < 11)
               stamp_now = stamp_now - $urandom_range(1, 5000);
            else if (roll >= 11 && roll < 35)
               stamp_now = stamp_now + $urandom_range(0, burst);
            else if (roll >= 35 && roll < 90)
               stamp_now = stamp_now + $urandom_range(0, base);
            else if (roll >= 90)
               stamp_now = stamp_now + $urandom_range(base, 4 * base);
            add_pulse(CMD_PUSH, stamp_now, $urandom);
         end
      end
      wait_drained();
   endtask

   initial begin
      logic [31:0] rnd_window;
      logic [63:0] rnd_rate;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset values, then a tight window for the hand-built cases
      verify_register(CSR_WINDOW, WINDOW_RST);
      verify_register(CSR_MAX_RATE, MAX_RATE_RST);
      verify_register(CSR_SPACING, SPACING_RST);
      program_register(CSR_WINDOW, 32'd100);
      program_register(CSR_MAX_RATE, 32'd65536000);
      program_register(CSR_SPACING, 32'd50);

      add_pulse(CMD_FLUSH, '0, '0);                       // flush with nothing buffered
      add_pulse(CMD_PUSH, 48'd0, 32'h0000_0000);
      add_pulse(CMD_FLUSH, '1, '1);                       // flush with one pulse
      add_pulse(CMD_PUSH, 48'd0, 32'hFFFF_FFFF);          // zero span, below window
      add_pulse(CMD_PUSH, 48'd100, 32'hA5A5_A5A5);        // first marker, then spacing blocks
      add_pulse(CMD_PUSH, 48'd5000, 32'h5A5A_5A5A);       // within rate, forwarded
      add_pulse(CMD_PUSH, 48'd5000, $urandom);
      add_pulse(CMD_FLUSH, '0, '0);                       // zero-span judgement under flush
      add_pulse(CMD_PUSH, 48'hFFFF_FFFF_FFFF, $urandom);  // largest stamp
      add_pulse(CMD_PUSH, 48'd5, $urandom);               // stamp wraps around
      add_pulse(CMD_PUSH, 48'd200, $urandom);
      add_pulse(CMD_PUSH, 48'd260, $urandom);
      add_pulse(CMD_PUSH, 48'd300, $urandom);             // marker spacing met
      add_pulse(CMD_PUSH, 48'd1_000_000, $urandom);       // two forwards in one step
      add_pulse(CMD_FLUSH, '0, '0);
      wait_drained();

      // random phases, extremes included
      run_phase(32'd50000, 32'd13107200, 32'd20000, 70);
      run_phase(32'd0, 32'hFFFF_FFFF, 32'd0, 70);
      run_phase(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 70);
      rnd_window = $urandom_range(1000, 200000);
      rnd_rate   = (64'd16_000_000 * 64'd65536 / rnd_window) * $urandom_range(50, 200) / 100;
      run_phase(rnd_window, rnd_rate[31:0], $urandom_range(0, 2 * rnd_window), 70);
      run_phase(WINDOW_RST, MAX_RATE_RST, SPACING_RST, 70);

      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   // watchdog
   initial begin
      #20_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
